/* src/assert_macros.svh */
// Assertion macros used by byte_alu_with_bcd_and_flags.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define BALU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("balu assertion failed");

// Checked on every rising clock edge, reset included.
`define BALU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("balu assertion failed");

`endif

/* src/balu_pkg.sv */
package balu_pkg;

  // Operation codes. Code 15 is unused and behaves as a no-op.
  typedef enum logic [3:0] {
    OP_ADC = 4'd0,
    OP_SBC = 4'd1,
    OP_AND = 4'd2,
    OP_ORA = 4'd3,
    OP_EOR = 4'd4,
    OP_CMP = 4'd5,
    OP_ASL = 4'd6,
    OP_LSR = 4'd7,
    OP_ROL = 4'd8,
    OP_ROR = 4'd9,
    OP_INC = 4'd10,
    OP_DEC = 4'd11,
    OP_BIT = 4'd12,
    OP_LD  = 4'd13,
    OP_LDN = 4'd14
  } balu_op_e;

  // Bit positions in the status byte.
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // Decimal correction constants.
  localparam logic [4:0] BCD_LO_LIMIT = 5'h0A;
  localparam logic [9:0] BCD_HI_LIMIT = 10'h0A0;
  localparam logic [9:0] BCD_HI_FIX   = 10'h060;
  localparam logic [9:0] BCD_DIGIT_CY = 10'h010;
  localparam logic [7:0] BCD_NINES    = 8'h99;
  localparam logic [9:0] CARRY_LIMIT  = 10'h100;

  // One operation as it enters the ALU.
  typedef struct packed {
    balu_op_e   op;
    logic [7:0] target_value;
    logic [7:0] source_value;
    logic [7:0] status_in;
  } balu_req_t;

  // One result as it leaves the ALU.
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] status_out;
  } balu_rsp_t;

endpackage

/* src/balu_if.sv */
// Operation channel: valid, ready and the operand beat.
interface balu_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] op;
  logic [7:0] target_value;
  logic [7:0] source_value;
  logic [7:0] status_in;

  modport source (output valid, output op, output target_value,
                  output source_value, output status_in, input ready);
  modport sink (input valid, input op, input target_value,
                input source_value, input status_in, output ready);
endinterface

// Result channel: valid, ready and the result beat.
interface balu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic [7:0] status_out;

  modport source (output valid, output result, output status_out, input ready);
  modport sink (input valid, input result, input status_out, output ready);
endinterface

/* src/byte_alu_with_bcd_and_flags.sv */
// Channel   Dir  Handshake      Beat contents
// in_ch_i   in   valid/ready    op, target_value, source_value, status_in
// out_ch_o  out  valid/ready    result, status_out
//
// One operation is accepted per cycle while in_ch_i.ready is high; the ALU
// logic sits between the operand register and the result register, each a
// valid/ready stage. Reset (rst_ni, asynchronous, active low) empties both
// stages. A stalled result beat holds; the operand stage keeps filling
// until both stages are full, then in_ch_i.ready drops.
`include "assert_macros.svh"

module byte_alu_with_bcd_and_flags (
  input  logic              clk_i,
  input  logic              rst_ni,
  balu_in_if.sink           in_ch_i,
  balu_out_if.source        out_ch_o
);

  balu_pkg::balu_req_t in_req, mid_req;
  balu_pkg::balu_rsp_t core_rsp, out_rsp;
  logic                mid_valid, mid_ready;
  logic                keep_target_op, dec_arith_op, dec_nz_kept;

  // Operand beat as a struct.
  assign in_req.op           = balu_pkg::balu_op_e'(in_ch_i.op);
  assign in_req.target_value = in_ch_i.target_value;
  assign in_req.source_value = in_ch_i.source_value;
  assign in_req.status_in    = in_ch_i.status_in;

  // Operand register.
  balu_stage #(.T(balu_pkg::balu_req_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_ch_i.valid),
    .ready_o (in_ch_i.ready),
    .data_i  (in_req),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid_req)
  );

  // ALU logic.
  balu_core u_core (
    .req_i (mid_req),
    .rsp_o (core_rsp)
  );

  // Result register.
  balu_stage #(.T(balu_pkg::balu_rsp_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (core_rsp),
    .valid_o (out_ch_o.valid),
    .ready_i (out_ch_o.ready),
    .data_o  (out_rsp)
  );

  assign out_ch_o.result     = out_rsp.result;
  assign out_ch_o.status_out = out_rsp.status_out;

  // Operation classes and flag checks used by the assertions below.
  assign keep_target_op = (mid_req.op == balu_pkg::OP_CMP) || (mid_req.op == balu_pkg::OP_BIT);
  assign dec_arith_op   = mid_req.status_in[balu_pkg::FLAG_D] &&
                          ((mid_req.op == balu_pkg::OP_ADC) || (mid_req.op == balu_pkg::OP_SBC));
  assign dec_nz_kept    =
      (core_rsp.status_out[balu_pkg::FLAG_N] == mid_req.status_in[balu_pkg::FLAG_N]) &&
      (core_rsp.status_out[balu_pkg::FLAG_Z] == mid_req.status_in[balu_pkg::FLAG_Z]);

  // An accepted operation is in the operand register on the next edge.
  `BALU_ASSERT(a_in_to_mid, in_ch_i.valid && in_ch_i.ready |=> mid_valid)

  // A result beat comes from the operand stage or is a held beat.
  `BALU_ASSERT(a_out_source, $rose(out_ch_o.valid) |-> $past(mid_valid))

  // Compare and bit test leave the destination byte alone.
  `BALU_ASSERT(a_keep_target, mid_valid && keep_target_op |-> core_rsp.result == mid_req.target_value)

  // Decimal add and subtract keep N and Z.
  `BALU_ASSERT(a_dec_nz, mid_valid && dec_arith_op |-> dec_nz_kept)

  // While reset is held, no beat is held in either stage.
  `BALU_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_ch_o.valid && !mid_valid)

endmodule

/* src/balu_stage.sv */
// Pipeline register stage with valid/ready flow control.
// A new beat is taken whenever the stage is empty or its beat leaves this cycle.
module balu_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q, valid_d;
  T     data_q;

  // Flow control.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded only on an accepted beat.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/balu_core.sv */
// Combinational ALU: one operation, one result byte and status byte.
module balu_core (
  input  balu_pkg::balu_req_t req_i,
  output balu_pkg::balu_rsp_t rsp_o
);

  logic [7:0] t, s, st, r;
  logic       c, dec;
  logic [8:0] bin_add, bin_sub;
  logic [9:0] bcd_add, bcd_sub, sum;
  logic [7:0] diff, nines_s;

  // Decimal add of two bytes with nibble correction.
  function automatic logic [9:0] bcd_sum(input logic [7:0] a, input logic [7:0] b,
                                         input logic cin);
    logic [4:0] lo;
    logic [9:0] hi;
    lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
    hi = {2'b0, a[7:4], 4'b0} + {2'b0, b[7:4], 4'b0};
    if (lo >= balu_pkg::BCD_LO_LIMIT) begin
      lo = lo - balu_pkg::BCD_LO_LIMIT;
      hi = hi + balu_pkg::BCD_DIGIT_CY;
    end
    if (hi >= balu_pkg::BCD_HI_LIMIT) begin
      hi = hi + balu_pkg::BCD_HI_FIX;
    end
    return hi + {5'b0, lo};
  endfunction

  assign t   = req_i.target_value;
  assign s   = req_i.source_value;
  assign c   = req_i.status_in[balu_pkg::FLAG_C];
  assign dec = req_i.status_in[balu_pkg::FLAG_D];

  // Binary and decimal adders for add and subtract.
  assign bin_add = {1'b0, t} + {1'b0, s} + {8'b0, c};
  assign bin_sub = {1'b0, t} + {1'b0, ~s} + {8'b0, c};
  assign nines_s = balu_pkg::BCD_NINES - s;
  assign bcd_add = bcd_sum(t, s, c);
  assign bcd_sub = bcd_sum(t, nines_s, c);
  assign diff    = t - s;

  // Operation select and flag update.
  always_comb begin
    r   = t;
    st  = req_i.status_in;
    sum = '0;
    case (req_i.op)
      balu_pkg::OP_ADC: begin
        sum = dec ? bcd_add : {1'b0, bin_add};
        st[balu_pkg::FLAG_C] = sum >= balu_pkg::CARRY_LIMIT;
        st[balu_pkg::FLAG_V] = (s[7] ^ sum[7]) & (t[7] ^ sum[7]);
        r = sum[7:0];
        if (!dec) begin
          st[balu_pkg::FLAG_Z] = (r == 8'h00);
          st[balu_pkg::FLAG_N] = r[7];
        end
      end
      balu_pkg::OP_SBC: begin
        sum = dec ? bcd_sub : {1'b0, bin_sub};
        st[balu_pkg::FLAG_C] = sum >= balu_pkg::CARRY_LIMIT;
        st[balu_pkg::FLAG_V] = ~(s[7] ^ sum[7]) & (t[7] ^ sum[7]);
        r = sum[7:0];
        if (!dec) begin
          st[balu_pkg::FLAG_Z] = (r == 8'h00);
          st[balu_pkg::FLAG_N] = r[7];
        end
      end
      balu_pkg::OP_AND: begin
        r = t & s;
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_ORA: begin
        r = t | s;
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_EOR: begin
        r = t ^ s;
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_CMP: begin
        st[balu_pkg::FLAG_C] = (t >= s);
        st[balu_pkg::FLAG_Z] = (t == s);
        st[balu_pkg::FLAG_N] = diff[7];
      end
      balu_pkg::OP_ASL: begin
        st[balu_pkg::FLAG_C] = t[7];
        r = {t[6:0], 1'b0};
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_LSR: begin
        st[balu_pkg::FLAG_C] = t[0];
        r = {1'b0, t[7:1]};
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_ROL: begin
        st[balu_pkg::FLAG_C] = t[7];
        r = {t[6:0], c};
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_ROR: begin
        st[balu_pkg::FLAG_C] = t[0];
        r = {c, t[7:1]};
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_INC: begin
        r = t + 8'd1;
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_DEC: begin
        r = t - 8'd1;
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_BIT: begin
        st[balu_pkg::FLAG_Z] = ((s & t) == 8'h00);
        st[balu_pkg::FLAG_V] = t[6];
        st[balu_pkg::FLAG_N] = t[7];
      end
      balu_pkg::OP_LD: begin
        r = s;
        st[balu_pkg::FLAG_Z] = (r == 8'h00);
        st[balu_pkg::FLAG_N] = r[7];
      end
      balu_pkg::OP_LDN: begin
        r = s;
      end
      default: begin
        r = t;
      end
    endcase
  end

  assign rsp_o.result     = r;
  assign rsp_o.status_out = st;

endmodule
